// ===== src/ndf_pkg.sv =====
// Shared types and constants for the normalized difference frame block.
package ndf_pkg;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 16;
   localparam int PIXEL_W    = 8;
   localparam int GAIN_W     = 16;
   localparam int VALUE_W    = 16;
   localparam int CSR_INDEX_W = 1;

   localparam int PRODUCT_W  = GAIN_W + PIXEL_W;
   localparam int SUM_W      = PRODUCT_W + 1;
   localparam int QUO_W      = 15;
   localparam int NUM_W      = PRODUCT_W + QUO_W;
   localparam int COUNT_W    = $clog2(QUO_W);
   localparam int IDX_WIDE_W = 21;

   localparam logic [QUO_W-1:0]   RATIO_CODE = QUO_W'(510 * 64);
   localparam logic [SUM_W-1:0]   SMALL_SUM  = SUM_W'(10 * 256);
   localparam logic [VALUE_W-1:0] MIN_RESET  = VALUE_W'(32767);
   localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(256);

   localparam int FRAME_PIXELS_DEFAULT = 65536;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_GAIN  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_GAIN = 1'd1;

   typedef enum logic [1:0] {
      OP_START,
      OP_LOAD,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type               op;
      logic                 in_frame;
      logic [INDEX_W-1:0]   pixel_index;
      logic [PIXEL_W-1:0]   first_pixel;
      logic [PIXEL_W-1:0]   second_pixel;
   } entry_type;

endpackage

// ===== src/ndf_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module ndf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ndf_front.sv =====
// Front end: accepts commands, drops the ones with no effect and classifies the rest.
module ndf_front #(
   parameter int FRAME_PIXELS = ndf_pkg::FRAME_PIXELS_DEFAULT
) (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ndf_pkg::CMD_W-1:0]   req_cmd,
   input  logic [ndf_pkg::INDEX_W-1:0] req_pixel_index,
   input  logic [ndf_pkg::PIXEL_W-1:0] req_first_pixel,
   input  logic [ndf_pkg::PIXEL_W-1:0] req_second_pixel,
   input  logic                        queue_full,
   output logic                        push,
   output ndf_pkg::entry_type          push_entry
);

   logic [ndf_pkg::IDX_WIDE_W-1:0] idx_wide;
   logic                           in_frame;
   logic                           keep;
   ndf_pkg::op_type                op;

   assign idx_wide = {{(ndf_pkg::IDX_WIDE_W - ndf_pkg::INDEX_W){1'b0}}, req_pixel_index};
   assign in_frame = idx_wide < ndf_pkg::IDX_WIDE_W'(FRAME_PIXELS);

   always_comb begin
      op   = ndf_pkg::OP_START;
      keep = 1'b0;
      unique case (req_cmd)
         ndf_pkg::CMD_START: begin
            op   = ndf_pkg::OP_START;
            keep = 1'b1;
         end
         ndf_pkg::CMD_LOAD: begin
            op   = ndf_pkg::OP_LOAD;
            keep = in_frame;
         end
         ndf_pkg::CMD_READ: begin
            op   = ndf_pkg::OP_READ;
            keep = 1'b1;
         end
         default: begin
            op   = ndf_pkg::OP_START;
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && keep;

   assign push_entry.op           = op;
   assign push_entry.in_frame     = in_frame;
   assign push_entry.pixel_index  = req_pixel_index;
   assign push_entry.first_pixel  = req_first_pixel;
   assign push_entry.second_pixel = req_second_pixel;

endmodule

// ===== src/ndf_queue.sv =====
// Short command queue between the front end and the execution back end.
module ndf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ndf_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ndf_pkg::entry_type head
);

   localparam int AW = (ndf_pkg::QUEUE_DEPTH > 1) ? $clog2(ndf_pkg::QUEUE_DEPTH) : 1;

   ndf_pkg::entry_type entries_ff [ndf_pkg::QUEUE_DEPTH];
   logic [AW-1:0]      wr_ptr_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [AW:0]        count_ff;

   assign full  = count_ff == (AW + 1)'(ndf_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entries_ff[wr_ptr_ff] <= push_entry;
            wr_ptr_ff <= (wr_ptr_ff == AW'(ndf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(ndf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/ndf_back.sv =====
// Back end: ratio computation with a serial divider, frame store access and frame minimum.
module ndf_back #(
   parameter int FRAME_PIXELS = ndf_pkg::FRAME_PIXELS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic [ndf_pkg::GAIN_W-1:0]                        first_gain,
   input  logic [ndf_pkg::GAIN_W-1:0]                        second_gain,
   input  logic                                              queue_empty,
   input  ndf_pkg::entry_type                                head,
   output logic                                              pop,
   output logic                                              ram_wr_en,
   output logic [((FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1)-1:0] ram_wr_addr,
   output logic [ndf_pkg::VALUE_W-1:0]                       ram_wr_data,
   output logic                                              ram_rd_en,
   output logic [((FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1)-1:0] ram_rd_addr,
   input  logic [ndf_pkg::VALUE_W-1:0]                       ram_rd_data,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output logic [ndf_pkg::VALUE_W-1:0]                       rsp_shifted_value,
   output logic signed [ndf_pkg::VALUE_W-1:0]                rsp_frame_minimum
);

   localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   typedef enum logic [2:0] {
      IDLE,
      SUM,
      SCALE,
      DIVIDE,
      WRITE,
      READ_WAIT
   } state_type;

   state_type                           state_ff;
   logic [ADDR_W-1:0]                   addr_ff;
   logic [ndf_pkg::PRODUCT_W-1:0]       u_ff;
   logic [ndf_pkg::PRODUCT_W-1:0]       v_ff;
   logic [ndf_pkg::SUM_W-1:0]           sum_ff;
   logic [ndf_pkg::PRODUCT_W-1:0]       mag_ff;
   logic                                neg_ff;
   logic [ndf_pkg::SUM_W-1:0]           rem_ff;
   logic [ndf_pkg::QUO_W-1:0]           low_ff;
   logic [ndf_pkg::COUNT_W-1:0]         count_ff;
   logic signed [ndf_pkg::VALUE_W-1:0]  min_ff;
   logic                                rsp_valid_ff;
   logic [ndf_pkg::VALUE_W-1:0]         shifted_ff;
   logic signed [ndf_pkg::VALUE_W-1:0]  minimum_ff;

   logic [ndf_pkg::IDX_WIDE_W-1:0]      idx_wide;
   logic [ADDR_W-1:0]                   head_addr;
   logic                                out_free;
   logic [ndf_pkg::NUM_W-1:0]           numerator;
   logic [ndf_pkg::SUM_W:0]             trial;
   logic [ndf_pkg::SUM_W+1:0]           trial_diff;
   logic                                trial_fits;
   logic signed [ndf_pkg::VALUE_W-1:0]  ratio;
   logic signed [ndf_pkg::VALUE_W:0]    read_diff;
   logic [ndf_pkg::VALUE_W-1:0]         read_shifted;

   assign idx_wide  = {{(ndf_pkg::IDX_WIDE_W - ndf_pkg::INDEX_W){1'b0}}, head.pixel_index};
   assign head_addr = idx_wide[ADDR_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == IDLE) && !queue_empty
                      && ((head.op != ndf_pkg::OP_READ) || out_free);

   assign numerator  = ndf_pkg::NUM_W'(mag_ff) * ndf_pkg::NUM_W'(ndf_pkg::RATIO_CODE);
   assign trial      = {rem_ff, low_ff[ndf_pkg::QUO_W-1]};
   assign trial_diff = {1'b0, trial} - {2'b00, sum_ff};
   assign trial_fits = !trial_diff[ndf_pkg::SUM_W+1];

   assign ratio = neg_ff ? -$signed({1'b0, low_ff}) : $signed({1'b0, low_ff});

   assign read_diff    = $signed({ram_rd_data[ndf_pkg::VALUE_W-1], ram_rd_data})
                         - $signed({min_ff[ndf_pkg::VALUE_W-1], min_ff});
   assign read_shifted = read_diff[ndf_pkg::VALUE_W] ? '0 : read_diff[ndf_pkg::VALUE_W-1:0];

   assign ram_rd_en   = pop && (head.op == ndf_pkg::OP_READ) && head.in_frame;
   assign ram_rd_addr = head_addr;
   assign ram_wr_en   = state_ff == WRITE;
   assign ram_wr_addr = addr_ff;
   assign ram_wr_data = ratio;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         min_ff       <= ndf_pkg::MIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (pop) begin
                  unique case (head.op)
                     ndf_pkg::OP_START: begin
                        min_ff <= ndf_pkg::MIN_RESET;
                     end
                     ndf_pkg::OP_LOAD: begin
                        addr_ff  <= head_addr;
                        u_ff     <= ndf_pkg::PRODUCT_W'(first_gain)
                                    * ndf_pkg::PRODUCT_W'(head.first_pixel);
                        v_ff     <= ndf_pkg::PRODUCT_W'(second_gain)
                                    * ndf_pkg::PRODUCT_W'(head.second_pixel);
                        state_ff <= SUM;
                     end
                     ndf_pkg::OP_READ: begin
                        if (head.in_frame) begin
                           state_ff <= READ_WAIT;
                        end else begin
                           shifted_ff   <= '0;
                           minimum_ff   <= min_ff;
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     default: begin
                        state_ff <= IDLE;
                     end
                  endcase
               end
            end
            SUM: begin
               sum_ff   <= {1'b0, u_ff} + {1'b0, v_ff};
               neg_ff   <= v_ff > u_ff;
               mag_ff   <= (v_ff > u_ff) ? (v_ff - u_ff) : (u_ff - v_ff);
               state_ff <= SCALE;
            end
            SCALE: begin
               if (sum_ff < ndf_pkg::SMALL_SUM) begin
                  low_ff   <= '0;
                  state_ff <= WRITE;
               end else begin
                  rem_ff   <= {1'b0, numerator[ndf_pkg::NUM_W-1:ndf_pkg::QUO_W]};
                  low_ff   <= numerator[ndf_pkg::QUO_W-1:0];
                  count_ff <= ndf_pkg::COUNT_W'(ndf_pkg::QUO_W - 1);
                  state_ff <= DIVIDE;
               end
            end
            DIVIDE: begin
               rem_ff   <= trial_fits ? trial_diff[ndf_pkg::SUM_W-1:0]
                                      : trial[ndf_pkg::SUM_W-1:0];
               low_ff   <= {low_ff[ndf_pkg::QUO_W-2:0], trial_fits};
               count_ff <= count_ff - 1'b1;
               if (count_ff == '0) begin
                  state_ff <= WRITE;
               end
            end
            WRITE: begin
               if (ratio < min_ff) begin
                  min_ff <= ratio;
               end
               state_ff <= IDLE;
            end
            READ_WAIT: begin
               shifted_ff   <= read_shifted;
               minimum_ff   <= min_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_shifted_value = shifted_ff;
   assign rsp_frame_minimum = minimum_ff;

endmodule

// ===== src/normalized_difference_frame.sv =====
// Top level of the normalized difference frame block: registers, queue, back end and frame store.
//
//   Channel   Direction  Handshake             Carries
//   req_      in         req_valid/req_stall   cmd, pixel_index, first_pixel, second_pixel
//   rsp_      out        rsp_valid/rsp_stall   shifted_value, frame_minimum
//   csr_      in         csr_valid/csr_ready   index, data (gain registers)
//
// A load passes through the back-end states SUM, SCALE, DIVIDE and WRITE; DIVIDE runs the
// serial restoring divider and is skipped when the weighted sum is too small to divide. A read
// waits in READ_WAIT for the registered frame store read, unless it is out of frame; a start
// is handled in IDLE. Commands with no effect are dropped at the input and never queued.
// The two-entry queue lets the input run ahead; a read also waits until any held result is taken.
// Reset clears control state only; frame store entries are undefined until loaded.
module normalized_difference_frame #(
   parameter int FRAME_PIXELS = ndf_pkg::FRAME_PIXELS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ndf_pkg::CMD_W-1:0]             req_cmd,
   input  logic [ndf_pkg::INDEX_W-1:0]           req_pixel_index,
   input  logic [ndf_pkg::PIXEL_W-1:0]           req_first_pixel,
   input  logic [ndf_pkg::PIXEL_W-1:0]           req_second_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ndf_pkg::VALUE_W-1:0]           rsp_shifted_value,
   output logic signed [ndf_pkg::VALUE_W-1:0]    rsp_frame_minimum,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ndf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ndf_pkg::GAIN_W-1:0]            csr_data
);

   localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   logic [ndf_pkg::GAIN_W-1:0]  first_gain_ff;
   logic [ndf_pkg::GAIN_W-1:0]  second_gain_ff;

   logic                        push;
   ndf_pkg::entry_type          push_entry;
   logic                        queue_full;
   logic                        queue_empty;
   logic                        pop;
   ndf_pkg::entry_type          head;

   logic                        ram_wr_en;
   logic [ADDR_W-1:0]           ram_wr_addr;
   logic [ndf_pkg::VALUE_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [ADDR_W-1:0]           ram_rd_addr;
   logic [ndf_pkg::VALUE_W-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_gain_ff  <= ndf_pkg::GAIN_RESET;
         second_gain_ff <= ndf_pkg::GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ndf_pkg::CSR_FIRST_GAIN:  first_gain_ff  <= csr_data;
            ndf_pkg::CSR_SECOND_GAIN: second_gain_ff <= csr_data;
            default: begin
               first_gain_ff <= first_gain_ff;
            end
         endcase
      end
   end

   ndf_front #(
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pixel_index  (req_pixel_index),
      .req_first_pixel  (req_first_pixel),
      .req_second_pixel (req_second_pixel),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   ndf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   ndf_back #(
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .first_gain        (first_gain_ff),
      .second_gain       (second_gain_ff),
      .queue_empty       (queue_empty),
      .head              (head),
      .pop               (pop),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_shifted_value (rsp_shifted_value),
      .rsp_frame_minimum (rsp_frame_minimum)
   );

   ndf_ram #(
      .WIDTH(ndf_pkg::VALUE_W),
      .DEPTH(FRAME_PIXELS)
   ) u_ratio_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== dv/ndf_checker.sv =====
// Checker for the normalized difference frame block: predicts every readout and compares it.
`timescale 1ns / 100ps
module ndf_checker #(
   parameter int FRAME_PIXELS = ndf_pkg::FRAME_PIXELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [ndf_pkg::CMD_W-1:0]          req_cmd,
   input  logic [ndf_pkg::INDEX_W-1:0]        req_pixel_index,
   input  logic [ndf_pkg::PIXEL_W-1:0]        req_first_pixel,
   input  logic [ndf_pkg::PIXEL_W-1:0]        req_second_pixel,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [ndf_pkg::VALUE_W-1:0]        rsp_shifted_value,
   input  logic signed [ndf_pkg::VALUE_W-1:0] rsp_frame_minimum,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ndf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ndf_pkg::GAIN_W-1:0]         csr_data,
   output int                                 failures,
   output int                                 outstanding,
   output int                                 compared
);
   import ndf_pkg::*;

   typedef struct {
      logic [VALUE_W-1:0]        shifted_value;
      logic signed [VALUE_W-1:0] frame_minimum;
   } readout_type;

   readout_type               expected_readouts[$];
   logic [GAIN_W-1:0]         first_weight = GAIN_RESET;
   logic [GAIN_W-1:0]         second_weight = GAIN_RESET;
   logic signed [VALUE_W-1:0] stored_ratio [FRAME_PIXELS];
   logic signed [VALUE_W-1:0] lowest_ratio = MIN_RESET;
   int                        fail_total = 0;
   int                        compared_total = 0;

   // Weighted normalized difference in signed Q10.6, truncated toward zero.
   function automatic logic signed [VALUE_W-1:0] weighted_ratio(
      input logic [PIXEL_W-1:0] first_pixel,
      input logic [PIXEL_W-1:0] second_pixel
   );
      logic [PRODUCT_W-1:0] first_term;
      logic [PRODUCT_W-1:0] second_term;
      logic [PRODUCT_W-1:0] magnitude;
      logic [SUM_W-1:0]     total;
      logic [63:0]          quotient;
      first_term = PRODUCT_W'(first_weight) * PRODUCT_W'(first_pixel);
      second_term = PRODUCT_W'(second_weight) * PRODUCT_W'(second_pixel);
      total = SUM_W'(first_term) + SUM_W'(second_term);
      magnitude = (second_term > first_term) ? second_term - first_term
                                             : first_term - second_term;
      if (total < SMALL_SUM) return '0;
      quotient = (64'(magnitude) * 64'(RATIO_CODE)) / 64'(total);
      return (second_term > first_term) ? -VALUE_W'(quotient) : VALUE_W'(quotient);
   endfunction

   always @(posedge clock) begin
      readout_type               want;
      logic signed [VALUE_W-1:0] ratio;
      int                        delta;
      if (reset) begin
         first_weight = GAIN_RESET;
         second_weight = GAIN_RESET;
         lowest_ratio = MIN_RESET;
         expected_readouts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_GAIN: first_weight = csr_data;
               CSR_SECOND_GAIN: second_weight = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_readouts.size() == 0) begin
               $error("Readout transfer with no readout expected: shifted_value %0d",
                      rsp_shifted_value);
               fail_total++;
            end else begin
               want = expected_readouts.pop_front();
               compared_total++;
               if (rsp_shifted_value !== want.shifted_value) begin
                  $error("shifted_value: expected %0d, got %0d", want.shifted_value,
                         rsp_shifted_value);
                  fail_total++;
               end
               if (rsp_frame_minimum !== want.frame_minimum) begin
                  $error("frame_minimum: expected %0d, got %0d", want.frame_minimum,
                         rsp_frame_minimum);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_START: lowest_ratio = MIN_RESET;
               CMD_LOAD: begin
                  if (int'(req_pixel_index) < FRAME_PIXELS) begin
                     ratio = weighted_ratio(req_first_pixel, req_second_pixel);
                     stored_ratio[req_pixel_index] = ratio;
                     if (ratio < lowest_ratio) lowest_ratio = ratio;
                  end
               end
               CMD_READ: begin
                  want.shifted_value = '0;
                  want.frame_minimum = lowest_ratio;
                  if (int'(req_pixel_index) < FRAME_PIXELS) begin
                     delta = int'(stored_ratio[req_pixel_index]) - int'(lowest_ratio);
                     if (delta > 0) want.shifted_value = VALUE_W'(delta);
                  end
                  expected_readouts.push_back(want);
               end
               default: ;
            endcase
         end
      end
      failures <= fail_total;
      outstanding <= expected_readouts.size();
      compared <= compared_total;
   end

endmodule

// ===== dv/normalized_difference_frame_test.sv =====
// Testbench top for the normalized difference frame block: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module normalized_difference_frame_test;
   import ndf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
   localparam int RANDOM_ITEMS = 1550;
   localparam int GAIN_STEPS = 9;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_NS = 4_000_000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [CMD_W-1:0]            req_cmd = CMD_START;
   logic [INDEX_W-1:0]          req_pixel_index = '0;
   logic [PIXEL_W-1:0]          req_first_pixel = '0;
   logic [PIXEL_W-1:0]          req_second_pixel = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [VALUE_W-1:0]          rsp_shifted_value;
   logic signed [VALUE_W-1:0]   rsp_frame_minimum;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_FIRST_GAIN;
   logic [GAIN_W-1:0]           csr_data = '0;

   int failures;
   int outstanding;
   int compared;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;
   int hold_left = 0;
   bit written [0:(1 << INDEX_W) - 1];
   int written_list[$];
   int load_count = 0;
   int read_count = 0;
   int start_count = 0;
   int noise_count = 0;
   int gain_count = 0;

   always #2 clock = ~clock;

   normalized_difference_frame u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_pixel_index(req_pixel_index),
      .req_first_pixel(req_first_pixel),
      .req_second_pixel(req_second_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_shifted_value(rsp_shifted_value),
      .rsp_frame_minimum(rsp_frame_minimum),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   ndf_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_pixel_index(req_pixel_index),
      .req_first_pixel(req_first_pixel),
      .req_second_pixel(req_second_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_shifted_value(rsp_shifted_value),
      .rsp_frame_minimum(rsp_frame_minimum),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .failures(failures),
      .outstanding(outstanding),
      .compared(compared)
   );

   // A long hold on the readout side lets the block fill up and push back on its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   task automatic send_item(
      input logic [CMD_W-1:0]   cmd,
      input logic [INDEX_W-1:0] pixel_index,
      input logic [PIXEL_W-1:0] first_pixel,
      input logic [PIXEL_W-1:0] second_pixel
   );
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pixel_index <= pixel_index;
      req_first_pixel <= first_pixel;
      req_second_pixel <= second_pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (cmd)
         CMD_LOAD: begin
            load_count++;
            if (!written[pixel_index]) begin
               written[pixel_index] = 1'b1;
               written_list.push_back(pixel_index);
            end
         end
         CMD_READ: read_count++;
         CMD_START: start_count++;
         default: noise_count++;
      endcase
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] first_gain, input logic [GAIN_W-1:0] second_gain);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_GAIN;
      csr_data <= first_gain;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_SECOND_GAIN;
      csr_data <= second_gain;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gain_count++;
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return PIXEL_W'($urandom_range(0, 6));
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_item();
      int roll;
      int span;
      logic [INDEX_W-1:0] pixel_index;
      roll = $urandom_range(0, 99);
      span = written_list.size();
      if (roll < 6) begin
         send_item(CMD_START, INDEX_W'($urandom), PIXEL_W'($urandom), PIXEL_W'($urandom));
      end else if (roll < 10) begin
         send_item(CMD_NONE, INDEX_W'($urandom), PIXEL_W'($urandom), PIXEL_W'($urandom));
      end else if (roll < 55 || span == 0) begin
         if ($urandom_range(0, 3) == 0) pixel_index = INDEX_W'($urandom);
         else pixel_index = INDEX_W'($urandom_range(0, 255));
         send_item(CMD_LOAD, pixel_index, pick_pixel(), pick_pixel());
      end else begin
         if ($urandom_range(0, 1) == 0)
            pixel_index = INDEX_W'(written_list[$urandom_range(0, span - 1)]);
         else
            pixel_index = INDEX_W'(written_list[span - 1 -
                                   $urandom_range(0, (span > 16) ? 15 : span - 1)]);
         send_item(CMD_READ, pixel_index, PIXEL_W'($urandom), PIXEL_W'($urandom));
      end
   endtask

   initial begin
      #(WATCHDOG_NS);
      $error("Run timed out with %0d readouts still expected", outstanding);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [GAIN_W-1:0] first_gain;
      logic [GAIN_W-1:0] second_gain;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct <= 19;
      rx_idle_pct <= 83;

      send_item(CMD_START, 16'h0000, 8'h00, 8'h00);
      send_item(CMD_LOAD, 16'h0000, 8'hFF, 8'h00);
      send_item(CMD_LOAD, 16'hFFFF, 8'h00, 8'hFF);
      send_item(CMD_LOAD, 16'h5555, 8'hFF, 8'hFF);
      send_item(CMD_LOAD, 16'hAAAA, 8'd4, 8'd5);
      send_item(CMD_LOAD, 16'h0001, 8'h00, 8'h00);
      send_item(CMD_READ, 16'h0000, 8'hFF, 8'hFF);
      send_item(CMD_READ, 16'hFFFF, 8'h00, 8'h00);
      send_item(CMD_READ, 16'h5555, 8'h00, 8'h00);
      send_item(CMD_READ, 16'hAAAA, 8'h00, 8'h00);
      send_item(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF);
      send_item(CMD_START, 16'hFFFF, 8'hFF, 8'hFF);
      send_item(CMD_LOAD, 16'h0002, 8'd200, 8'd100);
      send_item(CMD_READ, 16'hFFFF, 8'h00, 8'h00);
      send_item(CMD_READ, 16'h0000, 8'h00, 8'h00);
      send_item(CMD_LOAD, 16'h0003, 8'd10, 8'd0);
      send_item(CMD_LOAD, 16'h0004, 8'd9, 8'd0);
      send_item(CMD_LOAD, 16'h0005, 8'd5, 8'd5);
      send_item(CMD_READ, 16'h0003, 8'h00, 8'h00);
      send_item(CMD_READ, 16'h0004, 8'h00, 8'h00);
      send_item(CMD_READ, 16'h0005, 8'h00, 8'h00);
      send_item(CMD_START, 16'h0000, 8'h00, 8'h00);
      send_item(CMD_READ, 16'h0001, 8'h00, 8'h00);

      for (int step = 0; step < GAIN_STEPS; step++) begin
         settle();
         if (step == 3) begin
            tx_idle_pct <= 83;
            rx_idle_pct <= 19;
         end else if (step == 6) begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
         end
         case (step)
            0: begin first_gain = '0; second_gain = '0; end
            1: begin first_gain = '1; second_gain = '1; end
            3: begin first_gain = '1; second_gain = '0; end
            4: begin first_gain = '0; second_gain = '1; end
            5: begin
               first_gain = GAIN_W'($urandom_range(128, 512));
               second_gain = GAIN_W'($urandom_range(128, 512));
            end
            6: begin first_gain = GAIN_RESET; second_gain = GAIN_RESET; end
            8: begin first_gain = GAIN_W'(1); second_gain = '1; end
            default: begin
               first_gain = GAIN_W'($urandom);
               second_gain = GAIN_W'($urandom);
            end
         endcase
         set_gains(first_gain, second_gain);
         for (int n = 0; n < RANDOM_ITEMS / GAIN_STEPS; n++) begin
            if (n == 40 && step % 3 == 1) hold_req <= ~hold_req;
            random_item();
         end
      end
      settle();

      $display("Covered %0d pixel loads, %0d readouts, %0d frame starts, %0d unused commands,",
               load_count, read_count, start_count, noise_count);
      $display("over %0d written gain pairs; %0d readouts compared.", gain_count, compared);
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
